FILE: hdl/rdl_pkg.sv
`default_nettype none

package rdl_pkg;

  // item opcodes; the fourth code is ignored
  typedef enum logic [1:0] {
    OP_WRITE_REC = 2'd0,
    OP_WRITE_OFF = 2'd1,
    OP_LOOKUP    = 2'd2
  } op_t;

  // lookup result codes
  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NOT_FOUND  = 2'd1,
    STS_BAD_INDEX  = 2'd2,
    STS_BAD_EXTENT = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RECORD_COUNT = 3'd0,
    CFG_OFFSET_COUNT = 3'd1,
    CFG_DATA_START   = 3'd2,
    CFG_DATA_END     = 3'd3,
    CFG_FILE_SIZE    = 3'd4
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK
  } state_t;

  // one stored resource record
  typedef struct packed {
    logic [15:0] rtype;
    logic [15:0] id;
    logic [15:0] index;
  } rec_t;

  // lookup key, broadcast to every cell
  typedef struct packed {
    logic [15:0] rtype;
    logic [15:0] id;
    logic        any;
  } key_t;

  // token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [15:0] idx;
  } tok_t;

  // settings the extent check works from
  typedef struct packed {
    logic [31:0] base_off;
    logic [31:0] end_lim;
    logic [31:0] file_size;
    logic [16:0] noff;
  } ext_cfg_t;

  // one result item
  typedef struct packed {
    status_t     status;
    logic [31:0] start;
    logic [31:0] size;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/rdl_if.sv
`default_nettype none

// input item channel
interface rdl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  slot;
  logic [15:0] type_value;
  logic [15:0] id_value;
  logic [15:0] index_value;
  logic [31:0] offset_value;
  logic        match_any;

  modport source (
    output valid, op, slot, type_value, id_value, index_value, offset_value, match_any,
    input  ready
  );
  modport sink (
    input  valid, op, slot, type_value, id_value, index_value, offset_value, match_any,
    output ready
  );
endinterface

// result item channel
interface rdl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] res_start;
  logic [31:0] res_size;

  modport source (
    output valid, status, res_start, res_size,
    input  ready
  );
  modport sink (
    input  valid, status, res_start, res_size,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/rdl_cell.sv
`default_nettype none

module rdl_cell
  import rdl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire rec_t wr_rec,
  input  wire logic active,
  input  wire key_t key,
  input  wire tok_t tok_in,
  output tok_t      tok_out
);

  rec_t rec_r;
  tok_t tok_r;
  tok_t tok_nxt;
  logic hit;

  // record storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_r <= wr_rec;
    end
  end

  // compare against the broadcast key
  assign hit = active && (rec_r.id == key.id) && (key.any || (rec_r.rtype == key.rtype));

  // first match claims the token, later cells pass it on
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.found && hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = rec_r.index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

FILE: hdl/rdl_extent.sv
`default_nettype none

module rdl_extent
  import rdl_pkg::*;
#(
  parameter int MAX_OFFSETS = 256
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [7:0]  wr_slot,
  input  wire logic [31:0] wr_data,
  input  wire ext_cfg_t    cfg,
  input  wire tok_t        req,
  output res_t             res
);

  localparam int OFF_AW = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;

  logic [31:0]       mem [MAX_OFFSETS];
  logic [16:0]       slot_ext;
  logic [16:0]       idx_ext;
  logic [16:0]       idx_next;
  logic [OFF_AW-1:0] wr_addr;
  logic [OFF_AW-1:0] rd_addr0;
  logic [OFF_AW-1:0] rd_addr1;
  logic [31:0]       rd0_r;
  logic [31:0]       rd1_r;
  status_t           pre_r;
  status_t           pre_nxt;
  logic              has_next_r;
  logic [31:0]       end_val;
  logic              bad;

  assign slot_ext = 17'(wr_slot);
  assign wr_addr  = slot_ext[OFF_AW-1:0];
  assign idx_ext  = 17'(req.idx);
  assign idx_next = idx_ext + 17'd1;
  assign rd_addr0 = idx_ext[OFF_AW-1:0];
  assign rd_addr1 = idx_next[OFF_AW-1:0];

  // offset table, one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en && (slot_ext < 17'(MAX_OFFSETS))) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      rd0_r <= mem[rd_addr0];
      rd1_r <= mem[rd_addr1];
    end
  end

  // early status from the scan outcome
  always_comb begin
    if (!req.found) begin
      pre_nxt = STS_NOT_FOUND;
    end else if (idx_ext >= cfg.noff) begin
      pre_nxt = STS_BAD_INDEX;
    end else begin
      pre_nxt = STS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r      <= STS_NOT_FOUND;
      has_next_r <= 1'b0;
    end else if (req.valid) begin
      pre_r      <= pre_nxt;
      has_next_r <= (idx_next < cfg.noff);
    end
  end

  // extent check on the fetched offsets
  assign end_val = has_next_r ? rd1_r : cfg.end_lim;
  assign bad = (rd0_r < cfg.base_off) || (rd0_r >= end_val) || (end_val > cfg.file_size);

  always_comb begin
    res = '0;
    if (pre_r != STS_OK) begin
      res.status = pre_r;
    end else if (bad) begin
      res.status = STS_BAD_EXTENT;
    end else begin
      res.status = STS_OK;
      res.start  = rd0_r;
      res.size   = end_val - rd0_r;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/resource_directory_lookup.sv
`default_nettype none

// channel  dir  handshake      payload
// in_ch    in   valid/ready    op, slot, type_value, id_value, index_value,
//                              offset_value, match_any
// out_ch   out  valid/ready    status, res_start, res_size
// cfg_*    in   cfg_wr_en      cfg_index, cfg_wr_data
//
// a lookup runs from accept to result through the start register, then the token
// walking the row of record cells, one cell per cycle, then the offset table read
// registers and the check into the output register.
// reset clears control and configuration; both tables are undefined until written.
// a result held by a stalled sink does not stop new items from being accepted;
// only the next lookup result waits for it, and no item is accepted while it waits.

module resource_directory_lookup
  import rdl_pkg::*;
#(
  parameter int MAX_RECORDS = 256,
  parameter int MAX_OFFSETS = 256
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  rdl_in_if.sink           in_ch,
  rdl_out_if.source        out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wr_data
);

  state_t      state_r;
  state_t      state_nxt;
  logic [8:0]  rec_num_r;
  logic [8:0]  off_num_r;
  logic [31:0] base_off_r;
  logic [31:0] end_decl_r;
  logic [31:0] file_size_r;
  key_t        key_r;
  logic        start_r;
  logic        start_nxt;
  logic        in_acc;
  logic        lookup_acc;
  logic        rec_wr;
  logic        off_wr;
  logic        load_out;
  logic        out_valid_r;
  res_t        out_res_r;
  res_t        ext_res;
  rec_t        wr_rec;
  ext_cfg_t    ext_cfg;
  logic [16:0] off_cnt_ext;
  tok_t        tok [MAX_RECORDS+1];
  logic [MAX_RECORDS-1:0] tok_vld;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign lookup_acc = in_acc && (in_ch.op == OP_LOOKUP);
  assign rec_wr     = in_acc && (in_ch.op == OP_WRITE_REC);
  assign off_wr     = in_acc && (in_ch.op == OP_WRITE_OFF);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_num_r   <= '0;
      off_num_r   <= '0;
      base_off_r  <= '0;
      end_decl_r  <= '0;
      file_size_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RECORD_COUNT: rec_num_r   <= cfg_wr_data[8:0];
        CFG_OFFSET_COUNT: off_num_r   <= cfg_wr_data[8:0];
        CFG_DATA_START:   base_off_r  <= cfg_wr_data;
        CFG_DATA_END:     end_decl_r  <= cfg_wr_data;
        CFG_FILE_SIZE:    file_size_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // saturated offset count and clamped data end
  assign off_cnt_ext = 17'(off_num_r);

  always_comb begin
    ext_cfg.base_off  = base_off_r;
    ext_cfg.file_size = file_size_r;
    ext_cfg.noff      = (off_cnt_ext > 17'(MAX_OFFSETS)) ? 17'(MAX_OFFSETS) : off_cnt_ext;
    if ((end_decl_r > file_size_r) || (end_decl_r < base_off_r)) begin
      ext_cfg.end_lim = file_size_r;
    end else begin
      ext_cfg.end_lim = end_decl_r;
    end
  end

  // lookup key capture
  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      key_r.rtype <= in_ch.type_value;
      key_r.id    <= in_ch.id_value;
      key_r.any   <= in_ch.match_any;
    end
  end

  assign wr_rec.rtype = in_ch.type_value;
  assign wr_rec.id    = in_ch.id_value;
  assign wr_rec.index = in_ch.index_value;

  // token enters the first cell in the cycle after the lookup is accepted
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = start_r;
  end

  // row of record cells
  for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
    rdl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (rec_wr && (16'(g) == 16'(in_ch.slot))),
      .wr_rec  (wr_rec),
      .active  (16'(g) < 16'(rec_num_r)),
      .key     (key_r),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
    assign tok_vld[g] = tok[g+1].valid;
  end

  // offset table and extent check
  rdl_extent #(
    .MAX_OFFSETS (MAX_OFFSETS)
  ) u_extent (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (off_wr),
    .wr_slot (in_ch.slot),
    .wr_data (in_ch.offset_value),
    .cfg     (ext_cfg),
    .req     (tok[MAX_RECORDS]),
    .res     (ext_res)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (lookup_acc) state_nxt = ST_SCAN;
      ST_SCAN:  if (tok[MAX_RECORDS].valid) state_nxt = ST_CHECK;
      ST_CHECK: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    start_nxt = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE:  start_nxt = lookup_acc;
      ST_SCAN:  ;
      ST_CHECK: load_out = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= ext_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_res_r.status;
  assign out_ch.res_start = out_res_r.start;
  assign out_ch.res_size  = out_res_r.size;

`ifndef NO_ASSERTIONS
  // never more than one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld) <= 1)
    else $error("more than one lookup token in the cell row");

  // an idle block has no lookup in flight
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (tok_vld == '0) && !start_r)
    else $error("lookup token present while idle");

  // a found resource has a nonzero size
  a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == STS_OK)) |-> (out_res_r.size != 32'd0))
    else $error("ok result with zero size");

  // failed lookups report zero start and size
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status != STS_OK))
      |-> (out_res_r.start == 32'd0) && (out_res_r.size == 32'd0))
    else $error("failed lookup carries nonzero extent");
`endif

endmodule

`default_nettype wire
